[hw/rtl/ps2_scancode_line_editor_macros.svh]
// Assertion macros for the scancode line editor.
// Depends on nothing; included by the top level only.
`ifndef PS2_SCANCODE_LINE_EDITOR_MACROS_SVH
`define PS2_SCANCODE_LINE_EDITOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PS2LE_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("line editor check failed");

// The consequent must hold in the cycle after the antecedent.
`define PS2LE_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("line editor check failed");

`endif

[hw/rtl/ps2le_pkg.sv]
// Shared types, codes and the scancode ROM of the scancode line editor.
// Depends on nothing; used by every module of the block.
package ps2le_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int PTR_W = $clog2(BUFFER_DEPTH);

  // Input modes.
  localparam logic [1:0] MODE_KEY     = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_CONSUME = 2'd2;

  // Echo actions.
  localparam logic [1:0] ECHO_NONE  = 2'd0;
  localparam logic [1:0] ECHO_PRINT = 2'd1;
  localparam logic [1:0] ECHO_BS    = 2'd2;
  localparam logic [1:0] ECHO_NL    = 2'd3;

  // Commands passed from the front to the back.
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_CHAR    = 3'd1;
  localparam logic [2:0] OP_BS      = 3'd2;
  localparam logic [2:0] OP_ENTER   = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;
  localparam logic [2:0] OP_CONSUME = 3'd5;

  // Key codes and characters.
  localparam logic [7:0] RELEASE_BIT = 8'h80;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_NL       = 8'h0A;

  typedef struct packed {
    logic [2:0]       op;
    logic [7:0]       ch;
    logic [PTR_W-1:0] idx;
  } cmd_t;

  // Unshifted set 1 make code to ASCII; zero means no mapping.
  function automatic logic [7:0] key_rom(input logic [6:0] code);
    logic [7:0] c;
    c = 8'h00;
    case (code)
      7'h02: c = "1";   7'h03: c = "2";   7'h04: c = "3";   7'h05: c = "4";
      7'h06: c = "5";   7'h07: c = "6";   7'h08: c = "7";   7'h09: c = "8";
      7'h0A: c = "9";   7'h0B: c = "0";   7'h0C: c = "-";   7'h0D: c = "=";
      7'h0E: c = CH_BS; 7'h0F: c = 8'h09;
      7'h10: c = "q";   7'h11: c = "w";   7'h12: c = "e";   7'h13: c = "r";
      7'h14: c = "t";   7'h15: c = "y";   7'h16: c = "u";   7'h17: c = "i";
      7'h18: c = "o";   7'h19: c = "p";   7'h1A: c = "[";   7'h1B: c = "]";
      7'h1C: c = CH_NL; 7'h1E: c = "a";   7'h1F: c = "s";
      7'h20: c = "d";   7'h21: c = "f";   7'h22: c = "g";   7'h23: c = "h";
      7'h24: c = "j";   7'h25: c = "k";   7'h26: c = "l";
      7'h2C: c = "z";   7'h2D: c = "x";   7'h2E: c = "c";   7'h2F: c = "v";
      7'h30: c = "b";   7'h31: c = "n";   7'h32: c = "m";
      7'h39: c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/ps2le_queue.sv]
// Two-entry command queue between the front and the back of the line editor.
// Depends on ps2le_pkg for the command type.
module ps2le_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  ps2le_pkg::cmd_t push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output ps2le_pkg::cmd_t pop_cmd
);

  ps2le_pkg::cmd_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

[hw/rtl/ps2le_front.sv]
// Front of the line editor: accepts input transactions and classifies them.
// Depends on ps2le_pkg for codes, the command type and the scancode ROM.
module ps2le_front (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic [7:0]                  scancode,
  input  logic [ps2le_pkg::PTR_W-1:0] read_index,
  output logic                        push_valid,
  input  logic                        push_ready,
  output ps2le_pkg::cmd_t             push_cmd
);

  logic [7:0] rom_ch;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign rom_ch     = ps2le_pkg::key_rom(scancode[6:0]);

  // Turn a mode and scancode into one command for the back.
  always_comb begin
    push_cmd.op  = ps2le_pkg::OP_NONE;
    push_cmd.ch  = rom_ch;
    push_cmd.idx = read_index;
    unique case (mode)
      ps2le_pkg::MODE_KEY: begin
        if ((scancode & ps2le_pkg::RELEASE_BIT) != 8'h00 || rom_ch == 8'h00) begin
          push_cmd.op = ps2le_pkg::OP_NONE;
        end else if (rom_ch == ps2le_pkg::CH_BS) begin
          push_cmd.op = ps2le_pkg::OP_BS;
        end else if (rom_ch == ps2le_pkg::CH_NL) begin
          push_cmd.op = ps2le_pkg::OP_ENTER;
        end else begin
          push_cmd.op = ps2le_pkg::OP_CHAR;
        end
      end
      ps2le_pkg::MODE_READ:    push_cmd.op = ps2le_pkg::OP_READ;
      ps2le_pkg::MODE_CONSUME: push_cmd.op = ps2le_pkg::OP_CONSUME;
      default:                 push_cmd.op = ps2le_pkg::OP_NONE;
    endcase
  end

endmodule

[hw/rtl/ps2le_back.sv]
// Back of the line editor: holds the line buffer, cursor and ready flag,
// carries out commands and registers one result each. Depends on ps2le_pkg.
module ps2le_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  ps2le_pkg::cmd_t       cmd,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            echo_action,
  output logic [7:0]            echo_char,
  output logic                  line_ready,
  output logic [7:0]            line_length,
  output logic [7:0]            read_data
);

  localparam int PW = ps2le_pkg::PTR_W;
  localparam logic [PW-1:0] CURSOR_MAX = PW'(ps2le_pkg::BUFFER_DEPTH - 1);

  logic [7:0]    line_store [ps2le_pkg::BUFFER_DEPTH];
  logic [PW-1:0] cursor;
  logic [PW-1:0] cursor_next;
  logic          ready_flag;
  logic          ready_flag_next;
  logic          pop;
  logic          wr_en;
  logic [7:0]    wr_data;
  logic [1:0]    act;
  logic [7:0]    ch;
  logic          rd_hit;
  logic          rd_hit_q;
  logic [7:0]    rd_q;

  assign cmd_ready = !out_valid || out_ready;
  assign pop       = cmd_valid && cmd_ready;

  // Execute one command against the current line state.
  always_comb begin
    cursor_next     = cursor;
    ready_flag_next = ready_flag;
    wr_en           = 1'b0;
    wr_data         = cmd.ch;
    act             = ps2le_pkg::ECHO_NONE;
    ch              = 8'h00;
    rd_hit          = 1'b0;
    unique case (cmd.op)
      ps2le_pkg::OP_CHAR: begin
        if (cursor < CURSOR_MAX) begin
          wr_en       = 1'b1;
          cursor_next = cursor + PW'(1);
          act         = ps2le_pkg::ECHO_PRINT;
          ch          = cmd.ch;
        end
      end
      ps2le_pkg::OP_BS: begin
        if (cursor != '0) begin
          cursor_next = cursor - PW'(1);
          act         = ps2le_pkg::ECHO_BS;
        end
      end
      ps2le_pkg::OP_ENTER: begin
        wr_en           = 1'b1;
        wr_data         = 8'h00;
        ready_flag_next = 1'b1;
        act             = ps2le_pkg::ECHO_NL;
      end
      ps2le_pkg::OP_READ: begin
        rd_hit = (cmd.idx < cursor);
      end
      ps2le_pkg::OP_CONSUME: begin
        cursor_next     = '0;
        ready_flag_next = 1'b0;
      end
      default: begin
        act = ps2le_pkg::ECHO_NONE;
      end
    endcase
  end

  // Line state and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor     <= '0;
      ready_flag <= 1'b0;
      out_valid  <= 1'b0;
    end else if (pop) begin
      cursor     <= cursor_next;
      ready_flag <= ready_flag_next;
      out_valid  <= 1'b1;
    end else if (out_ready) begin
      out_valid  <= 1'b0;
    end
  end

  // Result register, held while the receiver stalls.
  always_ff @(posedge clk) begin
    if (pop) begin
      echo_action <= act;
      echo_char   <= ch;
      line_ready  <= ready_flag_next;
      line_length <= 8'(cursor_next);
      rd_hit_q    <= rd_hit;
    end
  end

  // Line buffer with one write port and a registered read port.
  always_ff @(posedge clk) begin
    if (pop && wr_en) begin
      line_store[cursor] <= wr_data;
    end
    if (pop) begin
      rd_q <= line_store[cmd.idx];
    end
  end

  assign read_data = rd_hit_q ? rd_q : 8'h00;

endmodule

[hw/rtl/ps2_scancode_line_editor.sv]
// PS/2 set 1 scancode line editor: channel ports in, one result per input.
// Depends on ps2le_pkg, ps2le_front, ps2le_queue, ps2le_back and the macros header.
//
// Usage: each input transaction carries mode, scancode and read_index. Mode 0
// feeds a key scancode, mode 1 reads one byte of the line buffer, mode 2
// consumes the line (clears the ready flag and the length). Every input
// transaction yields exactly one output transaction with echo_action,
// echo_char, line_ready, line_length and read_data, in input order.
// When the queue is empty, an accepted input is first stored as a command in
// the queue and then executed from there into the result register, which
// offers it. Throughput: one transaction per cycle while out_ready is high;
// the back executes one command per cycle into the result register, and the
// 256-byte line buffer has a single write port.
// Reset (rst, synchronous): the cursor and ready flag clear, the queue and
// the result register empty. The buffer contents are not cleared; only
// bytes below the length are ever returned.
// When the receiver holds out_ready low, the result stays in place, the back
// stops, and the two-entry queue fills before in_ready drops.
`include "ps2_scancode_line_editor_macros.svh"

module ps2_scancode_line_editor (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  input  logic [7:0] scancode,
  input  logic [7:0] read_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] echo_action,
  output logic [7:0] echo_char,
  output logic       line_ready,
  output logic [7:0] line_length,
  output logic [7:0] read_data
);

  logic            push_valid;
  logic            push_ready;
  ps2le_pkg::cmd_t push_cmd;
  logic            q_valid;
  logic            q_ready;
  ps2le_pkg::cmd_t q_cmd;

  // Classification of incoming transactions.
  ps2le_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .scancode   (scancode),
    .read_index (read_index),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Decoupling queue.
  ps2le_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  // Execution and result register.
  ps2le_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd_ready   (q_ready),
    .cmd         (q_cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .echo_action (echo_action),
    .echo_char   (echo_char),
    .line_ready  (line_ready),
    .line_length (line_length),
    .read_data   (read_data)
  );

  // A result that waits on the receiver stays offered and unchanged.
  `PS2LE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(line_length))
  // A read result carries no echo.
  `PS2LE_ASSERT_NOW(a_read_no_echo, clk, rst, out_valid && read_data != 8'h00, echo_action == ps2le_pkg::ECHO_NONE)
  // A character is shown only for a print action.
  `PS2LE_ASSERT_NOW(a_char_print, clk, rst, out_valid && echo_action != ps2le_pkg::ECHO_PRINT, echo_char == 8'h00)
  // A newline echo always comes with the line marked ready.
  `PS2LE_ASSERT_NOW(a_nl_ready, clk, rst, out_valid && echo_action == ps2le_pkg::ECHO_NL, line_ready)

endmodule

[tb/ps2le_reply_checker.sv]
// Result checker of the scancode line editor, with the keyboard codes that the bench uses.
// It predicts the result of every accepted input transaction and compares it with the output channel.
// Depends on ps2le_pkg.
`timescale 1ns / 1ps

package ps2le_tb_pkg;

  // Set 1 make codes of backspace, tab, enter and space.
  localparam logic [7:0] SC_BACKSPACE = 8'h0E;
  localparam logic [7:0] SC_TAB       = 8'h0F;
  localparam logic [7:0] SC_ENTER     = 8'h1C;
  localparam logic [7:0] SC_SPACE     = 8'h39;

  // The fourth mode value has no function in the block.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

endpackage

module ps2le_reply_checker
  import ps2le_pkg::*;
  import ps2le_tb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] mode,
  input  logic [7:0] scancode,
  input  logic [7:0] read_index,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] echo_action,
  input  logic [7:0] echo_char,
  input  logic       line_ready,
  input  logic [7:0] line_length,
  input  logic [7:0] read_data,
  output int         errors,
  output int         pending
);

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] ch;
    logic       ready;
    logic [7:0] length;
    logic [7:0] rdata;
  } reply_t;

  // Predicted editor state.
  logic [7:0] text_buf [BUFFER_DEPTH];
  int         held_count;
  logic       line_done;
  logic [7:0] keymap [128];

  // Replies still owed by the block, oldest first.
  reply_t     owed_replies [$];

  function automatic void place_row(logic [7:0] first, string keys);
    for (int i = 0; i < keys.len(); i++) begin
      keymap[first + i] = keys[i];
    end
  endfunction

  // Unshifted key layout; every code not placed here has no character.
  initial begin
    for (int i = 0; i < 128; i++) begin
      keymap[i] = 8'h00;
    end
    place_row(8'h02, "1234567890-=");
    place_row(8'h10, "qwertyuiop[]");
    place_row(8'h1E, "asdfghjkl");
    place_row(8'h2C, "zxcvbnm");
    keymap[SC_BACKSPACE] = CH_BS;
    keymap[SC_TAB]       = 8'h09;
    keymap[SC_ENTER]     = CH_NL;
    keymap[SC_SPACE]     = " ";
    errors     = 0;
    pending    = 0;
    held_count = 0;
    line_done  = 1'b0;
  end

  // Applies one input transaction to the predicted state and returns its reply.
  function automatic reply_t edit_line(logic [1:0] m, logic [7:0] code, logic [7:0] idx);
    reply_t     r;
    logic [7:0] ch;
    r = '0;
    case (m)
      MODE_KEY: begin
        if ((code & RELEASE_BIT) == 8'h00) begin
          ch = keymap[code[6:0]];
          if (ch == CH_BS) begin
            if (held_count > 0) begin
              held_count--;
              r.action = ECHO_BS;
            end
          end else if (ch == CH_NL) begin
            text_buf[held_count] = 8'h00;
            line_done = 1'b1;
            r.action  = ECHO_NL;
          end else if (ch != 8'h00 && held_count < BUFFER_DEPTH - 1) begin
            text_buf[held_count] = ch;
            held_count++;
            r.action = ECHO_PRINT;
            r.ch     = ch;
          end
        end
      end
      MODE_READ: begin
        if (idx < held_count) r.rdata = text_buf[idx];
      end
      MODE_CONSUME: begin
        line_done  = 1'b0;
        held_count = 0;
      end
      default: ;
    endcase
    r.ready  = line_done;
    r.length = held_count[7:0];
    return r;
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 30) begin
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    end
  endfunction

  // Predict on accepted input transactions and check accepted output transactions.
  always @(posedge clk) begin : watch
    reply_t want;
    if (rst) begin
      held_count = 0;
      line_done  = 1'b0;
      owed_replies.delete();
    end else begin
      if (in_valid && in_ready) begin
        owed_replies.push_back(edit_line(mode, scancode, read_index));
      end
      if (out_valid && out_ready) begin
        if (owed_replies.size() == 0) begin
          errors++;
          if (errors <= 30) begin
            $display("%0t ns: result with none expected, expected nothing, got action %0d",
                     $time, echo_action);
          end
        end else begin
          want = owed_replies.pop_front();
          compare_field("echo_action", 8'(want.action), 8'(echo_action));
          compare_field("echo_char", want.ch, echo_char);
          compare_field("line_ready", 8'(want.ready), 8'(line_ready));
          compare_field("line_length", want.length, line_length);
          compare_field("read_data", want.rdata, read_data);
        end
      end
    end
    pending = owed_replies.size();
  end

endmodule

[tb/testbench.sv]
// Top of the line editor bench: clock, reset, stimulus on both channels and the verdict.
// Depends on ps2le_pkg, ps2le_tb_pkg, ps2le_reply_checker and ps2_scancode_line_editor.
`timescale 1ns / 1ps

module testbench;
  import ps2le_pkg::*;
  import ps2le_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int USEFUL_ITEMS = 600;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] mode;
  logic [7:0] scancode;
  logic [7:0] read_index;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] echo_action;
  logic [7:0] echo_char;
  logic       line_ready;
  logic [7:0] line_length;
  logic [7:0] read_data;

  int mismatches;
  int outstanding;
  int cycles;
  int useful_sent;
  bit calm;
  bit long_hold;

  ps2_scancode_line_editor dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .scancode(scancode), .read_index(read_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .echo_action(echo_action), .echo_char(echo_char), .line_ready(line_ready),
    .line_length(line_length), .read_data(read_data)
  );

  ps2le_reply_checker line_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .scancode(scancode), .read_index(read_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .echo_action(echo_action), .echo_char(echo_char), .line_ready(line_ready),
    .line_length(line_length), .read_data(read_data),
    .errors(mismatches), .pending(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort a run that hangs.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls, plus one long hold-off while the sender keeps going.
  initial begin : receiver
    int n;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (80) @(negedge clk);
        long_hold = 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(negedge clk);
        end
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Offers one input transaction and waits until the block takes it.
  task automatic send_item(logic [1:0] m, logic [7:0] code, logic [7:0] idx);
    int gap;
    useful_sent++;
    @(negedge clk);
    in_valid   <= 1'b1;
    mode       <= m;
    scancode   <= code;
    read_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic press(logic [7:0] code);
    send_item(MODE_KEY, code, 8'($urandom));
  endtask

  task automatic read_at(logic [7:0] idx);
    send_item(MODE_READ, 8'($urandom), idx);
  endtask

  task automatic consume_line();
    send_item(MODE_CONSUME, 8'($urandom), 8'($urandom));
  endtask

  // A make code that yields a printable character or a tab.
  function automatic logic [7:0] printable_code();
    case ($urandom_range(0, 4))
      0: return 8'($urandom_range(8'h02, 8'h0D));
      1: return 8'($urandom_range(8'h10, 8'h1B));
      2: return 8'($urandom_range(8'h1E, 8'h26));
      3: return 8'($urandom_range(8'h2C, 8'h32));
      default: return ($urandom_range(0, 1) != 0) ? SC_SPACE : SC_TAB;
    endcase
  endfunction

  // One line as a user would type it, with a few slips, then an enter, reads and a consume, each now and then left out.
  task automatic type_line();
    int len;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0: press(SC_BACKSPACE);
        1: send_item(MODE_KEY, 8'($urandom), 8'($urandom));
        default: press(printable_code());
      endcase
    end
    if ($urandom_range(0, 9) != 0) press(SC_ENTER);
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 5) == 0) read_at(8'($urandom));
      else read_at(8'($urandom_range(0, len + 1)));
    end
    if ($urandom_range(0, 4) != 0) consume_line();
  endtask

  initial begin : stimulus
    rst         = 1'b1;
    in_valid    = 1'b0;
    mode        = MODE_KEY;
    scancode    = 8'h00;
    read_index  = 8'h00;
    calm        = 1'b0;
    long_hold   = 1'b0;
    useful_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: ignored codes, editing, enter twice, reads, the unused mode and consume.
    send_item(MODE_KEY, 8'h9E, 8'h00);
    send_item(MODE_KEY, 8'hFF, 8'hFF);
    send_item(MODE_KEY, 8'h00, 8'h00);
    send_item(MODE_KEY, 8'h7F, 8'h00);
    send_item(MODE_KEY, 8'h1D, 8'h00);
    press(SC_BACKSPACE);
    press(8'h1E);
    press(SC_SPACE);
    press(SC_TAB);
    press(8'h02);
    press(SC_BACKSPACE);
    press(SC_ENTER);
    press(SC_ENTER);
    press(8'h2C);
    read_at(8'd0);
    read_at(8'd1);
    read_at(8'd3);
    read_at(8'd4);
    read_at(8'd255);
    send_item(MODE_UNUSED, 8'hA5, 8'h5A);
    consume_line();
    read_at(8'd0);
    send_item(MODE_UNUSED, 8'h5A, 8'hA5);

    // Fill the buffer to its limit; the last characters are dropped.
    repeat (BUFFER_DEPTH + 1) press(printable_code());
    press(SC_ENTER);
    read_at(8'd254);
    read_at(8'd255);
    press(SC_BACKSPACE);
    press(printable_code());
    press(printable_code());
    consume_line();

    // Random part, opened by a burst against a stalled receiver.
    long_hold = 1'b1;
    calm      = 1'b1;
    repeat (20) press(printable_code());
    while (useful_sent < USEFUL_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) begin
        type_line();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_item(2'($urandom), 8'($urandom), 8'($urandom));
        end
      end
    end
    calm = 1'b0;

    // Drain and give the verdict.
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
